// ===== rtl/core/q24_8_fixed_point_alu_assert.svh =====
// assertion macros for the q24.8 arithmetic unit
// expects aclk and aresetn in the scope of the including module
`ifndef Q24_8_FIXED_POINT_ALU_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_ASSERT_SVH

// condition checked at every clock edge outside reset
`define Q8A_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// condition that implies another at the same edge
`define Q8A_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) else $error(msg);

// condition that implies another at the next edge
`define Q8A_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/q8alu_pkg.sv =====
// shared types, constants and helpers for the q24.8 arithmetic unit
// no dependencies
package q8alu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    // long division: bits retired per pipeline stage and stage count
    localparam int DIV_STEP  = 4;
    localparam int DIV_STG   = (DATA_W + FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int NUM_W     = DIV_STG * DIV_STEP;
    localparam int PROD_W    = 2 * DATA_W;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_CMP      = 4'd4,
        OP_MIN      = 4'd5,
        OP_MAX      = 4'd6,
        OP_INC      = 4'd7,
        OP_DEC      = 4'd8,
        OP_FROM_INT = 4'd9,
        OP_TO_INT   = 4'd10
    } op_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [DATA_W-1:0]  res;
        logic               gt;
        logic               lt;
        logic               eq;
        logic               ovf;
        logic               dz;
        logic               neg;
        logic [DATA_W-1:0]  mag_a;
        logic [DATA_W-1:0]  mag_b;
        logic [PROD_W-1:0]  prod;
        logic [NUM_W-1:0]   dnum;
        logic [DATA_W:0]    drem;
        logic [NUM_W-1:0]   dquo;
    } stage_t;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] res;
    } sat_t;

    // apply sign to a magnitude and saturate to the signed 32-bit range
    function automatic sat_t sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
        sat_t o;
        o.ovf = 1'b0;
        if (!neg && mag > PROD_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
            o.ovf = 1'b1;
            o.res = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (neg && mag > PROD_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
            o.ovf = 1'b1;
            o.res = {1'b1, {(DATA_W-1){1'b0}}};
        end else if (neg) begin
            o.res = -mag[DATA_W-1:0];
        end else begin
            o.res = mag[DATA_W-1:0];
        end
        return o;
    endfunction

endpackage

// ===== rtl/core/q24_8_fixed_point_alu.sv =====
// Each transfer passes the input stage register, the division stage registers and the output register, in order.
// Throughput: one transfer per cycle; the division retires 4 quotient bits per stage.
// The whole pipeline advances together and holds while the result waits.
// Reset (aresetn, synchronous, active low) clears all valid bits; data needs none.
// top level of the q24.8 arithmetic unit: pipelined add, sub, mul, div, compare, min/max, inc/dec, int conversions
// depends on q8alu_pkg and q24_8_fixed_point_alu_assert.svh
`include "q24_8_fixed_point_alu_assert.svh"

module q24_8_fixed_point_alu
    import q8alu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  s_tuser,   // kind [3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result [31:0], greater, less, equal, overflow, div_zero
);

    logic   en;
    logic   vld_reg  [0:DIV_STG];
    stage_t stg_reg  [0:DIV_STG];
    stage_t stg_next [0:DIV_STG];
    logic   out_vld_reg;
    logic [39:0] out_reg, out_next;

    // pipeline advances unless the result register is full and not taken
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // input stage: operand decode and the operations computed outright (all but mul and div)
    always_comb begin
        logic signed [DATA_W-1:0] a, b;
        logic signed [DATA_W:0]   sum;
        stage_t s;
        a = signed'(s_tdata[31:0]);
        b = signed'(s_tdata[63:32]);
        s = '0;
        s.kind  = s_tuser;
        s.neg   = a[DATA_W-1] ^ b[DATA_W-1];
        s.mag_a = a[DATA_W-1] ? -a : a;
        s.mag_b = b[DATA_W-1] ? -b : b;
        s.dnum  = NUM_W'({s.mag_a, {FRAC_BITS{1'b0}}});
        sum     = '0;
        case (s_tuser)
            OP_ADD, OP_SUB: begin
                sum = (s_tuser == OP_ADD) ? ({a[DATA_W-1], a} + {b[DATA_W-1], b})
                                          : ({a[DATA_W-1], a} - {b[DATA_W-1], b});
                s.ovf = sum[DATA_W] ^ sum[DATA_W-1];
                s.res = s.ovf ? {sum[DATA_W], {(DATA_W-1){~sum[DATA_W]}}}
                              : sum[DATA_W-1:0];
            end
            OP_CMP, OP_MIN, OP_MAX: begin
                s.gt = a > b;
                s.lt = a < b;
                s.eq = a == b;
                if (s_tuser == OP_MIN)      s.res = s.lt ? a : b;
                else if (s_tuser == OP_MAX) s.res = s.gt ? a : b;
            end
            OP_INC: begin
                s.ovf = a == {1'b0, {(DATA_W-1){1'b1}}};
                s.res = s.ovf ? a : a + DATA_W'(1);
            end
            OP_DEC: begin
                s.ovf = a == {1'b1, {(DATA_W-1){1'b0}}};
                s.res = s.ovf ? a : a - DATA_W'(1);
            end
            OP_FROM_INT: begin
                s.ovf = !((&a[DATA_W-1:DATA_W-1-FRAC_BITS]) ||
                          !(|a[DATA_W-1:DATA_W-1-FRAC_BITS]));
                s.res = s.ovf ? {a[DATA_W-1], {(DATA_W-1){~a[DATA_W-1]}}}
                              : {a[DATA_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            end
            OP_TO_INT: begin
                s.res = a >>> FRAC_BITS;
            end
            OP_DIV: begin
                s.dz = b == '0;
            end
            default: begin
                s.res = '0;
            end
        endcase
        stg_next[0] = s;
    end

    // division stages, with the multiply and its rounding riding in the first two
    for (genvar k = 1; k <= DIV_STG; k++) begin : g_stg
        always_comb begin
            stage_t s;
            logic [PROD_W-1:0] m;
            sat_t sm;
            s  = stg_reg[k-1];
            m  = '0;
            sm = '0;
            for (int j = 0; j < DIV_STEP; j++) begin
                s.drem = {s.drem[DATA_W-1:0], s.dnum[NUM_W-1]};
                s.dnum = {s.dnum[NUM_W-2:0], 1'b0};
                if (s.drem >= {1'b0, s.mag_b}) begin
                    s.drem = s.drem - {1'b0, s.mag_b};
                    s.dquo = {s.dquo[NUM_W-2:0], 1'b1};
                end else begin
                    s.dquo = {s.dquo[NUM_W-2:0], 1'b0};
                end
            end
            if (k == 1) begin
                s.prod = PROD_W'(s.mag_a) * PROD_W'(s.mag_b);
            end
            if (k == 2 && s.kind == OP_MUL) begin
                m  = (s.prod + PROD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                sm = sat_mag(s.neg, m);
                s.res = sm.res;
                s.ovf = sm.ovf;
            end
            stg_next[k] = s;
        end
    end

    // output stage: division rounding and result packing
    always_comb begin
        stage_t s;
        logic [NUM_W:0] q;
        sat_t sd;
        s  = stg_reg[DIV_STG];
        q  = {1'b0, s.dquo} + (NUM_W+1)'({s.drem[DATA_W-1:0], 1'b0} >= {1'b0, s.mag_b});
        sd = sat_mag(s.neg, PROD_W'(q));
        if (s.kind == OP_DIV) begin
            s.res = s.dz ? '0 : sd.res;
            s.ovf = s.dz ? 1'b0 : sd.ovf;
        end
        out_next = {3'b000, s.dz, s.ovf, s.eq, s.lt, s.gt, s.res};
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= DIV_STG; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0]  <= s_tvalid;
            for (int k = 1; k <= DIV_STG; k++) vld_reg[k] <= vld_reg[k-1];
            out_vld_reg <= vld_reg[DIV_STG];
        end
    end

    // stage data
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= DIV_STG; k++) stg_reg[k] <= stg_next[k];
            out_reg <= out_next;
        end
    end

    `Q8A_IMPLY(a_dz_clean, m_tvalid && m_tdata[36], !m_tdata[35] && m_tdata[31:0] == 32'd0, "divide by zero result not clean")
    `Q8A_IMPLY(a_cmp_excl, m_tvalid, $onehot0(m_tdata[34:32]), "compare flags not exclusive")
    `Q8A_NEXT(a_hold, out_vld_reg && !m_tready, out_vld_reg && $stable(out_reg) && $stable(vld_reg[DIV_STG]), "pipeline moved during stall")

endmodule

// ===== tb/q24_8_fixed_point_alu_tb.sv =====
// self-checking testbench for the q24.8 arithmetic unit: directed table then random traffic
// depends on q8alu_pkg and the q24_8_fixed_point_alu top level
module q24_8_fixed_point_alu_tb;
    import q8alu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = DIV_STG + 2;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 800;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] res;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        ovf;
        logic        dz;
    } alu_out_t;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
        logic        known;
        alu_out_t    want;
    } vec_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    alu_out_t    expected_q[$];
    int          errors;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    bit          pressure_go;

    q24_8_fixed_point_alu dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // saturate a 64-bit signed value into 32 bits
    function automatic logic [32:0] clamp_word(input longint v);
        if (v > 64'sd2147483647)  return {1'b1, MAXV};
        if (v < -64'sd2147483648) return {1'b1, MINV};
        return {1'b0, v[31:0]};
    endfunction

    // signed magnitude back to a saturated word
    function automatic logic [32:0] signed_mag(input bit neg, input longint unsigned mag);
        longint v;
        if (mag > 64'h1_0000_0000) mag = 64'h1_0000_0000;
        v = longint'(mag);
        return clamp_word(neg ? -v : v);
    endfunction

    function automatic alu_out_t alu_predict(input logic [3:0] kind,
                                             input logic [31:0] ra, input logic [31:0] rb);
        alu_out_t o;
        longint a, b;
        longint unsigned ma, mb, m;
        logic [32:0] s;
        bit neg;
        a = longint'(signed'(ra));
        b = longint'(signed'(rb));
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        neg = (a < 0) != (b < 0);
        o = '0;
        s = '0;
        case (kind)
            OP_ADD:      s = clamp_word(a + b);
            OP_SUB:      s = clamp_word(a - b);
            OP_MUL: begin
                m = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                s = signed_mag(neg, m);
            end
            OP_DIV: begin
                if (b == 0) o.dz = 1'b1;
                else s = signed_mag(neg, (2 * (ma << FRAC_BITS) + mb) / (2 * mb));
            end
            OP_CMP, OP_MIN, OP_MAX: begin
                o.gt = a > b;
                o.lt = a < b;
                o.eq = a == b;
                if (kind == OP_MIN) s = {1'b0, o.lt ? ra : rb};
                if (kind == OP_MAX) s = {1'b0, o.gt ? ra : rb};
            end
            OP_INC:      s = clamp_word(a + 1);
            OP_DEC:      s = clamp_word(a - 1);
            OP_FROM_INT: s = clamp_word(a * (64'sd1 <<< FRAC_BITS));
            OP_TO_INT:   s = {1'b0, 32'(a >>> FRAC_BITS)};
            default:     s = '0;
        endcase
        o.ovf = s[32];
        o.res = s[31:0];
        return o;
    endfunction

    // directed rows: known results only where obvious
    vec_t dir_tbl[] = '{
        '{OP_ADD, MAXV, 32'd1, 1'b1, '{MAXV, 0, 0, 0, 1, 0}},
        '{OP_ADD, MINV, MINV, 1'b1, '{MINV, 0, 0, 0, 1, 0}},
        '{OP_SUB, MINV, 32'd1, 1'b1, '{MINV, 0, 0, 0, 1, 0}},
        '{OP_SUB, 32'd0, MINV, 1'b1, '{MAXV, 0, 0, 0, 1, 0}},
        '{OP_MUL, 32'h0000_0180, 32'hffff_ff00, 1'b0, '0},
        '{OP_MUL, MINV, MINV, 1'b1, '{MAXV, 0, 0, 0, 1, 0}},
        '{OP_MUL, MAXV, MINV, 1'b1, '{MINV, 0, 0, 0, 1, 0}},
        '{OP_MUL, 32'h0000_0001, 32'h0000_0080, 1'b0, '0},
        '{OP_MUL, 32'hffff_ffff, 32'h0000_0080, 1'b0, '0},
        '{OP_DIV, 32'h1234_5678, 32'd0, 1'b1, '{32'd0, 0, 0, 0, 0, 1}},
        '{OP_DIV, MINV, 32'hffff_ffff, 1'b1, '{MAXV, 0, 0, 0, 1, 0}},
        '{OP_DIV, 32'h0000_0100, 32'h0000_0300, 1'b0, '0},
        '{OP_DIV, 32'hffff_fd00, 32'h0000_0200, 1'b0, '0},
        '{OP_CMP, 32'd5, 32'd5, 1'b1, '{32'd0, 0, 0, 1, 0, 0}},
        '{OP_CMP, MINV, MAXV, 1'b1, '{32'd0, 0, 1, 0, 0, 0}},
        '{OP_MIN, 32'd7, 32'd7, 1'b1, '{32'd7, 0, 0, 1, 0, 0}},
        '{OP_MAX, MAXV, MINV, 1'b1, '{MAXV, 1, 0, 0, 0, 0}},
        '{OP_INC, MAXV, 32'hdead_beef, 1'b1, '{MAXV, 0, 0, 0, 1, 0}},
        '{OP_DEC, MINV, 32'd0, 1'b1, '{MINV, 0, 0, 0, 1, 0}},
        '{OP_FROM_INT, 32'h0080_0000, 32'd0, 1'b1, '{MAXV, 0, 0, 0, 1, 0}},
        '{OP_FROM_INT, 32'hff7f_ffff, 32'd0, 1'b1, '{MINV, 0, 0, 0, 1, 0}},
        '{OP_TO_INT, 32'hffff_ff01, 32'd0, 1'b1, '{32'hffff_ffff, 0, 0, 0, 0, 0}},
        '{OP_TO_INT, MAXV, MAXV, 1'b1, '{32'h007f_ffff, 0, 0, 0, 0, 0}},
        '{4'd11, MAXV, MINV, 1'b1, '0},
        '{4'd15, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '0}
    };

    // random operand biased toward edges and small values
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return MAXV - $urandom_range(0, 2);
            1:       return MINV + $urandom_range(0, 2);
            2, 3:    return 32'($signed($urandom_range(0, 4096)) - 2048);
            4:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom();
        endcase
    endfunction

    // offer one item and wait for its transfer; the table row may carry a typed result
    task automatic send_item(input vec_t v);
        alu_out_t want;
        want = v.known ? v.want : alu_predict(v.kind, v.a, v.b);
        // sender idles at random before the offer
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= v.kind;
        s_tdata  <= {v.b, v.a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(want);
        @(negedge aclk);
    endtask

    task automatic send_random(input int n);
        vec_t v;
        repeat (n) begin
            v.kind  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                   : 4'($urandom_range(0, 10));
            v.a     = rand_operand();
            v.b     = ($urandom_range(0, 9) == 0) ? v.a : rand_operand();
            if ($urandom_range(0, 29) == 0) v.b = 32'd0;
            v.known = 1'b0;
            v.want  = '0;
            send_item(v);
        end
    endtask

    // receiver ready, stalls at random or holds off entirely
    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result check and watchdog
    always @(posedge aclk) begin
        alu_out_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WDOG_MAX) begin
                $display("** q24_8_fixed_point_alu: FAILED **");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got.res = m_tdata[31:0];
                got.gt  = m_tdata[32];
                got.lt  = m_tdata[33];
                got.eq  = m_tdata[34];
                got.ovf = m_tdata[35];
                got.dz  = m_tdata[36];
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.res !== want.res) begin
                        $error("result: expected %h, got %h", want.res, got.res); errors++;
                    end
                    if (got.gt !== want.gt) begin
                        $error("greater: expected %b, got %b", want.gt, got.gt); errors++;
                    end
                    if (got.lt !== want.lt) begin
                        $error("less: expected %b, got %b", want.lt, got.lt); errors++;
                    end
                    if (got.eq !== want.eq) begin
                        $error("equal: expected %b, got %b", want.eq, got.eq); errors++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $error("overflow: expected %b, got %b", want.ovf, got.ovf); errors++;
                    end
                    if (got.dz !== want.dz) begin
                        $error("div_zero: expected %b, got %b", want.dz, got.dz); errors++;
                    end
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (pressure_go);
        hold_off = 1'b1;
        repeat (3 * LATENCY + 40) @(negedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        int tries;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (dir_tbl[i]) send_item(dir_tbl[i]);

        // random phases with different idling and receiver stalls
        send_random(N_RANDOM / 4);
        send_idle_pct = 80;
        send_random(N_RANDOM / 5);
        send_idle_pct = 0;
        recv_stall_pct = 80;
        send_random(N_RANDOM / 5);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        send_random(N_RANDOM / 5);
        recv_stall_pct = 0;
        send_idle_pct = 0;
        pressure_go = 1'b1;
        send_random(N_RANDOM / 8);
        send_random(N_RANDOM / 16);
        s_tvalid <= 1'b0;

        // drain
        tries = 0;
        while (expected_q.size() != 0 && tries < WDOG_MAX) begin
            @(posedge aclk);
            tries++;
        end
        repeat (LATENCY + 4) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("** q24_8_fixed_point_alu: PASSED **");
        end else begin
            $display("** q24_8_fixed_point_alu: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/q8alu_pkg.sv
rtl/core/q24_8_fixed_point_alu.sv
tb/q24_8_fixed_point_alu_tb.sv
